// ===== src/pcxrle_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length line decoder.
// -----------------------------------------------------------------------------
package pcxrle_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned REG_W    = 16;
    localparam int unsigned CNT_W    = 6;
    localparam int unsigned CFG_IDX_W = 2;

    // Bytes above this value are count bytes
    localparam logic [BYTE_W-1:0] RUN_BASE = 8'd192;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;

    localparam logic [REG_W-1:0] LINE_LENGTH_RESET = 16'd1;
    localparam logic [REG_W-1:0] IMAGE_WIDTH_RESET = 16'd1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_count;   // capture run length from a count byte
        logic emit_lit;     // emit the input byte as a single pixel
        logic emit_first;   // emit the first pixel of a run from the input byte
        logic emit_run;     // emit a further pixel of a run from the held byte
        logic emit_err;     // emit an overrun error result
    } pcxrle_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic is_count;     // input byte is a count byte
        logic run_one;      // one pixel of the run is left
        logic too_long;     // pending run exceeds the bytes left in the line
        logic slot_free;    // output register can take a result this cycle
    } pcxrle_sts_t;

endpackage
`default_nettype wire

// ===== src/pcxrle_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcxrle_byte_if
// Valid/ready channel carrying one encoded stream byte per transaction.
// -----------------------------------------------------------------------------
interface pcxrle_byte_if;
    import pcxrle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);

endinterface
`default_nettype wire

// ===== src/pcxrle_pix_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcxrle_pix_if
// Valid/ready channel carrying one decoded pixel result per transaction.
// -----------------------------------------------------------------------------
interface pcxrle_pix_if;
    import pcxrle_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] pixel;
    logic              keep;
    logic              line_end;
    logic              run_last;
    logic              overrun;

    modport source (output valid, output pixel, output keep, output line_end,
                    output run_last, output overrun, input ready);
    modport sink   (input valid, input pixel, input keep, input line_end,
                    input run_last, input overrun, output ready);

endinterface
`default_nettype wire

// ===== src/pcx_rle_line_decoder_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Timing: a literal or error byte's result is registered; it shows the next cycle.
// Throughput: one pixel per cycle while the output is free; a count byte yields
// no result; a value byte blocks input until its run is out (run counter, one
// output register). Sustained: one literal byte per cycle while the output is free.
// Reset: rst_n is asynchronous, active low; it clears control state and sets
// both configuration registers to 1. No memory, no clearing pass.
// -----------------------------------------------------------------------------
// pcx_rle_line_decoder_core
// PCX run-length scan-line decoder: expands count/value pairs into pixels,
// tags column keep and line end, and flags a sticky overrun error.
// -----------------------------------------------------------------------------
module pcx_rle_line_decoder_core
    import pcxrle_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata,
    pcxrle_byte_if.sink               encoded,
    pcxrle_pix_if.source              decoded
);

    pcxrle_cmd_t cmd;
    pcxrle_sts_t sts;
    logic        in_ready;

    // Controller: owns the awaiting-value flag, the sticky error and the run state.
    pcxrle_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (encoded.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    assign encoded.ready = in_ready;

    // Datapath: holds configuration, column, run counter and the output register.
    pcxrle_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .in_byte      (encoded.stream_byte),
        .cmd          (cmd),
        .sts          (sts),
        .out_valid    (decoded.valid),
        .out_ready    (decoded.ready),
        .out_pixel    (decoded.pixel),
        .out_keep     (decoded.keep),
        .out_line_end (decoded.line_end),
        .out_run_last (decoded.run_last),
        .out_overrun  (decoded.overrun)
    );

    // At most one result source drives the output register per cycle.
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_lit, cmd.emit_first, cmd.emit_run, cmd.emit_err}))
        else $error("more than one emit command in a cycle");

    // A result is only loaded when the output register has room.
    a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit_lit || cmd.emit_first || cmd.emit_run || cmd.emit_err)
        |-> sts.slot_free)
        else $error("result loaded into an occupied output register");

    // No input transaction while a run is still expanding.
    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_run |-> !encoded.ready)
        else $error("input accepted during a run");

    // An error result is always a zero, final, dropped pixel.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (decoded.valid && decoded.overrun)
        |-> (decoded.run_last && !decoded.keep && !decoded.line_end
             && (decoded.pixel == '0)))
        else $error("malformed overrun result");

endmodule
`default_nettype wire

// ===== src/pcxrle_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcxrle_ctrl
// Decoder sequencer: classifies input bytes, steps runs, tracks sticky error.
// -----------------------------------------------------------------------------
module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire pcxrle_sts_t sts,
    output      pcxrle_cmd_t cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   await_reg, await_next;
    logic   err_reg,   err_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && sts.slot_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        await_next = await_reg;
        err_next   = err_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (err_reg)
                    begin
                        cmd.emit_err = 1'b1;
                    end
                    else if (await_reg)
                    begin
                        await_next = 1'b0;
                        if (sts.too_long)
                        begin
                            cmd.emit_err = 1'b1;
                            err_next     = 1'b1;
                        end
                        else
                        begin
                            cmd.emit_first = 1'b1;
                            if (!sts.run_one)
                            begin
                                state_next = ST_RUN;
                            end
                        end
                    end
                    else if (sts.is_count)
                    begin
                        cmd.load_count = 1'b1;
                        await_next     = 1'b1;
                    end
                    else
                    begin
                        cmd.emit_lit = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                // advance one pixel whenever the output register has room
                if (sts.slot_free)
                begin
                    cmd.emit_run = 1'b1;
                    if (sts.run_one)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            await_reg <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            await_reg <= await_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/pcxrle_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// pcxrle_dp
// Decoder datapath: configuration, run counter, column tracking, output stage.
// -----------------------------------------------------------------------------
module pcxrle_dp
    import pcxrle_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [REG_W-1:0]     cfg_wdata,
    input  wire logic [BYTE_W-1:0]    in_byte,
    input  wire pcxrle_cmd_t          cmd,
    output      pcxrle_sts_t          sts,
    output      logic                 out_valid,
    input  wire logic                 out_ready,
    output      logic [BYTE_W-1:0]    out_pixel,
    output      logic                 out_keep,
    output      logic                 out_line_end,
    output      logic                 out_run_last,
    output      logic                 out_overrun
);

    logic [REG_W-1:0]  line_length_reg;
    logic [REG_W-1:0]  image_width_reg;
    logic [REG_W-1:0]  column_reg, column_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] hold_reg;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] pixel_reg;
    logic              keep_reg, line_end_reg, run_last_reg, overrun_reg;

    logic [REG_W:0]    line_size;
    logic [REG_W:0]    remain;
    logic [REG_W:0]    col_inc;
    logic              at_end;
    logic              emit_pix;
    logic              emit_any;
    logic              len_write;

    // zero line length stands for a full 64Ki line
    assign line_size = (line_length_reg == '0) ? {1'b1, {REG_W{1'b0}}}
                                               : {1'b0, line_length_reg};
    assign remain    = line_size - {1'b0, column_reg};
    assign col_inc   = {1'b0, column_reg} + {{REG_W{1'b0}}, 1'b1};
    assign at_end    = (col_inc == line_size);

    assign emit_pix  = cmd.emit_lit || cmd.emit_first || cmd.emit_run;
    assign emit_any  = emit_pix || cmd.emit_err;
    assign len_write = cfg_we && (cfg_index == REG_LINE_LENGTH);

    assign sts.is_count  = (in_byte > RUN_BASE);
    assign sts.run_one   = (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1});
    assign sts.too_long  = ({{(REG_W+1-CNT_W){1'b0}}, cnt_reg} > remain);
    assign sts.slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        column_next = column_reg;
        if (len_write)
        begin
            column_next = '0;
        end
        else if (emit_pix)
        begin
            column_next = at_end ? '0 : col_inc[REG_W-1:0];
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.load_count)
        begin
            // count byte minus the base is its low six bits
            cnt_next = in_byte[CNT_W-1:0];
        end
        else if (cmd.emit_first || cmd.emit_run)
        begin
            cnt_next = cnt_reg - {{(CNT_W-1){1'b0}}, 1'b1};
        end
        else if (cmd.emit_err)
        begin
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= LINE_LENGTH_RESET;
            image_width_reg <= IMAGE_WIDTH_RESET;
            column_reg      <= '0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (len_write)
            begin
                line_length_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == REG_IMAGE_WIDTH))
            begin
                image_width_reg <= cfg_wdata;
            end
            column_reg <= column_next;
            cnt_reg    <= cnt_next;
            if (emit_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.emit_first)
        begin
            hold_reg <= in_byte;
        end
        if (cmd.emit_err)
        begin
            pixel_reg    <= '0;
            keep_reg     <= 1'b0;
            line_end_reg <= 1'b0;
            run_last_reg <= 1'b1;
            overrun_reg  <= 1'b1;
        end
        else if (emit_pix)
        begin
            pixel_reg    <= cmd.emit_run ? hold_reg : in_byte;
            keep_reg     <= (column_reg < image_width_reg);
            line_end_reg <= at_end;
            run_last_reg <= cmd.emit_lit || sts.run_one;
            overrun_reg  <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_pixel    = pixel_reg;
    assign out_keep     = keep_reg;
    assign out_line_end = line_end_reg;
    assign out_run_last = run_last_reg;
    assign out_overrun  = overrun_reg;

endmodule
`default_nettype wire
